[hw/rtl/qau_pkg.sv]
// Shared constants and types for the quaternion arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps
package qau_pkg;
	localparam int FRAC_BITS_DEF = 28;
	localparam int QDEPTH = 4;
	localparam logic [1:0] MODE_MUL = 2'd0;

	// One classified request handed from front to back
	typedef struct packed {
		logic              norm;
		logic              conj;
		logic signed [31:0] a_w, a_x, a_y, a_z;
		logic signed [31:0] b_w, b_x, b_y, b_z;
	} req_t;
endpackage

[hw/rtl/qau_front.sv]
// Front part: accepts requests, classifies the mode and queues them.
// Depends on qau_pkg.
`timescale 1ns / 1ps
module qau_front import qau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
	output logic        req_valid,
	output req_t        req,
	input  logic        req_take
);
	req_t mem_q [QDEPTH];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic push;

	assign busy = (cnt_q == 3'(QDEPTH));
	assign push = start && !busy;
	assign req_valid = (cnt_q != 3'd0);
	assign req = mem_q[rp_q];

	// Store a classified request
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= '{norm: (mode != MODE_MUL), conj: mode[1],
				a_w: a_w, a_x: a_x, a_y: a_y, a_z: a_z,
				b_w: b_w, b_x: b_x, b_y: b_y, b_z: b_z};
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (req_take && req_valid) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(req_take && req_valid);
		end
	end
endmodule

[hw/rtl/qau_back.sv]
// Back part: multiply and normalize sequencer, one request at a time.
// Depends on qau_pkg.
`timescale 1ns / 1ps
module qau_back import qau_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  req_t        req,
	output logic        req_take,
	output logic        done,
	output logic [31:0] r_w, r_x, r_y, r_z,
	output logic        saturated
);
	localparam int QB = 4 * FRAC_BITS + 1;       // quotient bits
	localparam int DW = 68;                       // sum of squares width
	localparam int RB = (QB + 1) / 2 + 1;         // root bits
	localparam int RW = RB + 3;
	localparam int PW = RB + 33;
	localparam int CW = $clog2(QB + 2) + 1;
	localparam int LH = (RB + 1) / 2;             // root bits per scale pass

	localparam logic [2:0] ST_IDLE = 3'd0, ST_SQ = 3'd1, ST_DIV = 3'd2,
		ST_SQRT = 3'd3, ST_SCALE = 3'd4, ST_MUL = 3'd5, ST_OUT = 3'd6;

	logic [2:0]  st_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]  comp_q;
	logic signed [32:0] q_q [4];
	logic signed [31:0] b_q [4];
	logic [DW-1:0] d_q;
	logic [DW:0]  rem_q;
	logic [QB:0] quo_q;
	logic [RW-1:0] srem_q;
	logic [RB-1:0] root_q;
	logic [31:0] res_q [4];
	logic sat_q;
	logic signed [95:0] acc_q;
	logic ph_q;
	logic [LH+32:0] part_q;

	assign req_take = (st_q == ST_IDLE) && req_valid;
	assign r_w = res_q[0]; assign r_x = res_q[1];
	assign r_y = res_q[2]; assign r_z = res_q[3];
	assign saturated = sat_q;
	assign done = (st_q == ST_OUT);

	// Saturate a wide signed value to 32 bits
	function automatic logic [32:0] sat32(input logic signed [PW+1:0] v);
		logic [32:0] r;
		if (v > $signed(PW'(32'h7fffffff))) r = {1'b1, 32'h7fffffff};
		else if (v < -$signed((PW+2)'(33'h080000000))) r = {1'b1, 32'h80000000};
		else r = {1'b0, v[31:0]};
		return r;
	endfunction

	// Hamilton product term for a component and term index
	logic signed [32:0] ma;
	logic signed [31:0] mb;
	logic mneg;
	always_comb begin
		ma = q_q[0]; mb = b_q[0]; mneg = 1'b0;
		case ({comp_q, cnt_q[1:0]})
			4'h0: begin ma = q_q[0]; mb = b_q[0]; end
			4'h1: begin ma = q_q[1]; mb = b_q[1]; mneg = 1'b1; end
			4'h2: begin ma = q_q[2]; mb = b_q[2]; mneg = 1'b1; end
			4'h3: begin ma = q_q[3]; mb = b_q[3]; mneg = 1'b1; end
			4'h4: begin ma = q_q[0]; mb = b_q[1]; end
			4'h5: begin ma = q_q[1]; mb = b_q[0]; end
			4'h6: begin ma = q_q[2]; mb = b_q[3]; end
			4'h7: begin ma = q_q[3]; mb = b_q[2]; mneg = 1'b1; end
			4'h8: begin ma = q_q[0]; mb = b_q[2]; end
			4'h9: begin ma = q_q[2]; mb = b_q[0]; end
			4'ha: begin ma = q_q[3]; mb = b_q[1]; end
			4'hb: begin ma = q_q[1]; mb = b_q[3]; mneg = 1'b1; end
			4'hc: begin ma = q_q[0]; mb = b_q[3]; end
			4'hd: begin ma = q_q[3]; mb = b_q[0]; end
			4'he: begin ma = q_q[1]; mb = b_q[2]; end
			default: begin ma = q_q[2]; mb = b_q[1]; mneg = 1'b1; end
		endcase
	end

	logic signed [65:0] prod;
	assign prod = ma * mb;

	// Divider and root step values
	logic [DW:0] rem_sh;
	logic div_ge;
	assign rem_sh = {rem_q[DW-1:0], (cnt_q == CW'(QB - 1))};
	assign div_ge = (rem_sh >= {1'b0, d_q});
	logic [RW-1:0] srem_sh, trial;
	logic [1:0] qpair;
	assign qpair = quo_q[QB -: 2];
	assign srem_sh = {srem_q[RW-3:0], qpair};
	assign trial = RW'({root_q, 2'b01});

	// Square of a component magnitude
	logic [32:0] mag;
	logic [65:0] msq;
	assign mag = q_q[comp_q][32] ? 33'(-q_q[comp_q]) : 33'(q_q[comp_q]);
	assign msq = mag * mag;

	// Scale product: root times |c| in two passes, floored
	logic [LH-1:0] half;
	logic [LH+32:0] pmul;
	logic [PW-1:0] sprod;
	logic signed [PW+1:0] sval, shv;
	logic [32:0] sres;
	assign half = ph_q ? LH'(root_q[RB-1:LH]) : root_q[LH-1:0];
	assign pmul = half * mag;
	assign sprod = PW'({pmul, {LH{1'b0}}}) + PW'(part_q);
	assign sval = q_q[comp_q][32] ? -$signed({2'b00, sprod}) : $signed({2'b00, sprod});
	assign shv = sval >>> FRAC_BITS;
	assign sres = sat32(shv);

	// Unit value for a zero norm
	logic [32:0] one_sat;
	assign one_sat = sat32((PW+2)'(1) <<< FRAC_BITS);

	// Final product sum of a component, shifted and saturated
	logic signed [95:0] term, accsum, shacc;
	logic [32:0] mres;
	assign term = mneg ? -96'(prod) : 96'(prod);
	assign accsum = acc_q + term;
	assign shacc = accsum >>> FRAC_BITS;
	always_comb begin
		if (shacc > 96'sh7fffffff) mres = {1'b1, 32'h7fffffff};
		else if (shacc < -96'sh80000000) mres = {1'b1, 32'h80000000};
		else mres = {1'b0, shacc[31:0]};
	end

	// Sequence one request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			case (st_q)
				ST_IDLE: if (req_valid) st_q <= req.norm ? ST_SQ : ST_MUL;
				ST_SQ: if (comp_q == 2'd3) st_q <= ST_DIV;
				ST_DIV: if (d_q == '0) st_q <= ST_OUT;
					else if (cnt_q == '0) st_q <= ST_SQRT;
				ST_SQRT: if (cnt_q == '0) st_q <= ST_SCALE;
				ST_SCALE: if (comp_q == 2'd3 && ph_q) st_q <= ST_OUT;
				ST_MUL: if (comp_q == 2'd3 && cnt_q[1:0] == 2'd3) st_q <= ST_OUT;
				ST_OUT: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				q_q[0] <= 33'($signed(req.a_w));
				q_q[1] <= req.conj ? -33'($signed(req.a_x)) : 33'($signed(req.a_x));
				q_q[2] <= req.conj ? -33'($signed(req.a_y)) : 33'($signed(req.a_y));
				q_q[3] <= req.conj ? -33'($signed(req.a_z)) : 33'($signed(req.a_z));
				b_q[0] <= req.b_w; b_q[1] <= req.b_x;
				b_q[2] <= req.b_y; b_q[3] <= req.b_z;
				comp_q <= '0; cnt_q <= '0; d_q <= '0; acc_q <= '0; sat_q <= 1'b0;
			end
			ST_SQ: begin
				d_q <= d_q + DW'(msq);
				comp_q <= comp_q + 2'd1;
				cnt_q <= CW'(QB - 1); rem_q <= '0; quo_q <= '0;
			end
			ST_DIV: begin
				if (d_q == '0) begin
					res_q[0] <= one_sat[31:0];
					sat_q <= one_sat[32];
					res_q[1] <= q_q[1][31:0]; res_q[2] <= q_q[2][31:0];
					res_q[3] <= q_q[3][31:0];
				end else begin
					rem_q <= div_ge ? rem_sh - {1'b0, d_q} : rem_sh;
					quo_q <= {quo_q[QB-1:0], div_ge};
					if (cnt_q == '0) begin
						cnt_q <= CW'(QB / 2); srem_q <= '0; root_q <= '0;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
			end
			ST_SQRT: begin
				if (srem_sh >= trial) begin
					srem_q <= srem_sh - trial;
					root_q <= {root_q[RB-2:0], 1'b1};
				end else begin
					srem_q <= srem_sh;
					root_q <= {root_q[RB-2:0], 1'b0};
				end
				quo_q <= {quo_q[QB-2:0], 2'b00};
				cnt_q <= cnt_q - 1'b1;
				comp_q <= '0;
				ph_q <= 1'b0;
			end
			ST_SCALE: begin
				if (!ph_q) begin
					part_q <= pmul;
					ph_q <= 1'b1;
				end else begin
					res_q[comp_q] <= sres[31:0];
					sat_q <= sat_q | sres[32];
					comp_q <= comp_q + 2'd1;
					ph_q <= 1'b0;
				end
			end
			ST_MUL: begin
				if (cnt_q[1:0] == 2'd3) begin
					res_q[comp_q] <= mres[31:0];
					sat_q <= sat_q | mres[32];
					acc_q <= '0;
					comp_q <= comp_q + 2'd1;
				end else begin
					acc_q <= accsum;
				end
				cnt_q <= CW'(cnt_q[1:0] + 2'd1);
			end
			default: ;
		endcase
	end
endmodule

[hw/rtl/quaternion_arith_unit_top.sv]
// Top level of the quaternion arithmetic unit: front queue and back sequencer.
// Depends on qau_pkg, qau_front, qau_back.
//
// channel  | handshake        | ports
// request  | start / busy     | mode, a_w..a_z, b_w..b_z
// result   | done (1 cycle)   | r_w..r_z, saturated
//
// Multiply takes the request, sums 16 product terms and strobes the result;
// normalize sums the component squares, then runs the bit-serial divider
// (4*FRAC_BITS+1 steps) and the square root (2*FRAC_BITS+1 steps) and scales each
// component in two passes; a zero norm skips division, root and scale. The back part
// takes one request at a time. The queue holds four requests; busy rises when it is full.
// Reset clears the queue and sequencer. The receiver cannot stall results.
`timescale 1ns / 1ps
module quaternion_arith_unit_top import qau_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
	output logic        done,
	output logic [31:0] r_w, r_x, r_y, r_z,
	output logic        saturated
);
	req_t req;
	logic req_valid, req_take;

	qau_front u_front (.clk, .arst_n, .start, .busy, .mode,
		.a_w, .a_x, .a_y, .a_z, .b_w, .b_x, .b_y, .b_z,
		.req_valid, .req, .req_take);

	qau_back #(.FRAC_BITS(FRAC_BITS)) u_back (.clk, .arst_n, .req_valid, .req,
		.req_take, .done, .r_w, .r_x, .r_y, .r_z, .saturated);
endmodule
